[src/counter_hash_bounded_random_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the counter hash generator
// Implication and next-cycle checks, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef COUNTER_HASH_BOUNDED_RANDOM_ASSERT_SVH
`define COUNTER_HASH_BOUNDED_RANDOM_ASSERT_SVH

// Same-cycle implication
`define CHBR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CHBR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/chbr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chbr_pkg
// Types, constants and datapath helpers for the counter hash generator.
// ----------------------------------------------------------------------------
package chbr_pkg;

  // Mixing constants
  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] FIN_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] FIN_MUL_B   = 64'h94d049bb133111eb;
  localparam logic [63:0] INDEX_MUL   = 64'hd1b54a32d192ed03;
  localparam int unsigned SEED_ROT    = 29;
  localparam int unsigned SHIFT_A     = 30;
  localparam int unsigned SHIFT_B     = 27;
  localparam int unsigned SHIFT_C     = 31;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W   = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEED_HIGH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEED_LOW  = 8'd1;

  // Pipeline geometry
  localparam int unsigned HASH_STAGES   = 13;
  localparam int unsigned DIV_BITS      = 2;
  localparam int unsigned DIV_STAGES    = 64 / DIV_BITS;

  // Request payloads
  typedef struct packed {
    logic [63:0] stream_number;
    logic [63:0] sequence_index;
    logic [31:0] upper_bound;
  } in_req_t;

  typedef struct packed {
    logic [63:0] raw_value;
    logic [31:0] bounded_value;
  } out_req_t;

  // Partial products of a 64x64 multiply kept modulo 2^64
  typedef struct packed {
    logic [63:0] lo;   // xl * cl
    logic [31:0] m0;   // low half of xh * cl
    logic [31:0] m1;   // low half of xl * ch
  } pp_t;

  function automatic pp_t mul_pp(input logic [63:0] x, input logic [63:0] c);
    pp_t p;
    p.lo = 64'(x[31:0]) * 64'(c[31:0]);
    p.m0 = x[63:32] * c[31:0];
    p.m1 = x[31:0] * c[63:32];
    return p;
  endfunction

  function automatic logic [63:0] mul_sum(input pp_t p);
    logic [31:0] hi;
    hi = p.lo[63:32] + p.m0 + p.m1;
    return {hi, p.lo[31:0]};
  endfunction

  function automatic logic [63:0] xorshr(input logic [63:0] x, input int unsigned k);
    return x ^ (x >> k);
  endfunction

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned k);
    return (x << k) | (x >> (64 - k));
  endfunction

  // Restoring division: DIV_BITS quotient bits per call
  function automatic logic [31:0] div_step(input logic [31:0] rem,
                                           input logic [DIV_BITS-1:0] bits,
                                           input logic [31:0] dvs);
    logic [32:0] t;
    logic [31:0] r;
    r = rem;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
      end
      r = t[31:0];
    end
    return r;
  endfunction

endpackage

[src/counter_hash_bounded_random.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counter_hash_bounded_random
// Counter-based hash: seed, stream and index mixed through a splitmix64 style
// finalizer, then reduced modulo a 32-bit bound.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  input   | in_valid, in_ready, in_data        | request in
//  result  | out_valid, out_ready, out_data     | request out
//  config  | cfg_we, cfg_index, cfg_wdata       | write only
//
// One request per cycle unless the output stalls; path of 13 hash stages, 32
// division stages at 2 quotient bits each, and 1 output register.
// Each multiply spans two hash stages: 32x32 partial products, then their 64-bit sum.
// Reset (synchronous) clears valid bits, output valid and both seed words.
// The pipeline advances unless its last stage is full and the output register
// holds an untaken result; empty slots still advance, so input keeps flowing.
// ----------------------------------------------------------------------------
`include "counter_hash_bounded_random_assert.svh"

module counter_hash_bounded_random
  import chbr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_req_t                in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_req_t               out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_wdata
);

  // Seed registers
  logic [63:0] seed_hi_r, seed_lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_hi_r <= '0;
      seed_lo_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEED_HIGH: seed_hi_r <= cfg_wdata;
        CFG_SEED_LOW:  seed_lo_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Flow control
  logic out_valid_r;
  out_req_t out_data_r;
  logic [DIV_STAGES-1:0] dv_r;
  logic slot_free, en, last_v;

  assign last_v    = dv_r[DIV_STAGES-1];
  assign slot_free = !out_valid_r || out_ready;
  assign en        = !last_v || slot_free;
  assign in_ready  = en;

  // Hash pipeline valid bits and bound
  logic [HASH_STAGES-1:0] hv_r;
  logic [31:0]            bnd_r [HASH_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= '0;
    end else if (en) begin
      hv_r <= {hv_r[HASH_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bnd_r[0] <= in_data.upper_bound;
      for (int i = 1; i < HASH_STAGES; i++) begin
        bnd_r[i] <= bnd_r[i-1];
      end
    end
  end

  // Hash datapath: two lanes through the first finalizer, then one lane
  pp_t         pps1_r, ppp1_r, pps4_r, ppp4_r, pps6_r, ppp6_r, pp9_r, pp11_r;
  logic [63:0] ms2_r, mp2_r, as3_r, ap3_r, cs5_r, cp5_r, es7_r, ep7_r;
  logic [63:0] mix8_r, c10_r, e12_r, raw13_r;

  always_ff @(posedge clk) begin
    if (en) begin
      // counter scrambling multiplies
      pps1_r  <= mul_pp(in_data.stream_number, GOLDEN_STEP);
      ppp1_r  <= mul_pp(in_data.sequence_index, INDEX_MUL);
      ms2_r   <= mul_sum(pps1_r);
      mp2_r   <= mul_sum(ppp1_r);
      // finalizer on each lane
      as3_r   <= ms2_r + GOLDEN_STEP;
      ap3_r   <= mp2_r + GOLDEN_STEP;
      pps4_r  <= mul_pp(xorshr(as3_r, SHIFT_A), FIN_MUL_A);
      ppp4_r  <= mul_pp(xorshr(ap3_r, SHIFT_A), FIN_MUL_A);
      cs5_r   <= mul_sum(pps4_r);
      cp5_r   <= mul_sum(ppp4_r);
      pps6_r  <= mul_pp(xorshr(cs5_r, SHIFT_B), FIN_MUL_B);
      ppp6_r  <= mul_pp(xorshr(cp5_r, SHIFT_B), FIN_MUL_B);
      es7_r   <= mul_sum(pps6_r);
      ep7_r   <= mul_sum(ppp6_r);
      // combine with seed, start the final finalizer
      mix8_r  <= (seed_lo_r ^ rotl(seed_hi_r, SEED_ROT)
                  ^ xorshr(es7_r, SHIFT_C) ^ xorshr(ep7_r, SHIFT_C)) + GOLDEN_STEP;
      pp9_r   <= mul_pp(xorshr(mix8_r, SHIFT_A), FIN_MUL_A);
      c10_r   <= mul_sum(pp9_r);
      pp11_r  <= mul_pp(xorshr(c10_r, SHIFT_B), FIN_MUL_B);
      e12_r   <= mul_sum(pp11_r);
      raw13_r <= xorshr(e12_r, SHIFT_C);
    end
  end

  // Division pipeline: remainder of raw by bound, MSB first
  logic [63:0] draw_r [DIV_STAGES];
  logic [31:0] drem_r [DIV_STAGES];
  logic [31:0] dbnd_r [DIV_STAGES];
  logic        src_v   [DIV_STAGES];
  logic [63:0] src_raw [DIV_STAGES];
  logic [31:0] src_rem [DIV_STAGES];
  logic [31:0] src_bnd [DIV_STAGES];

  always_comb begin
    src_v[0]   = hv_r[HASH_STAGES-1];
    src_raw[0] = raw13_r;
    src_rem[0] = '0;
    src_bnd[0] = bnd_r[HASH_STAGES-1];
    for (int k = 1; k < DIV_STAGES; k++) begin
      src_v[k]   = dv_r[k-1];
      src_raw[k] = draw_r[k-1];
      src_rem[k] = drem_r[k-1];
      src_bnd[k] = dbnd_r[k-1];
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int unsigned TOP = 63 - k * DIV_BITS;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (en) begin
        dv_r[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        draw_r[k] <= src_raw[k];
        dbnd_r[k] <= src_bnd[k];
        drem_r[k] <= div_step(src_rem[k], src_raw[k][TOP -: DIV_BITS], src_bnd[k]);
      end
    end
  end

  // Output register; a zero bound reduces to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= last_v;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && last_v) begin
      out_data_r.raw_value     <= draw_r[DIV_STAGES-1];
      out_data_r.bounded_value <= (dbnd_r[DIV_STAGES-1] == '0) ? '0
                                                               : drem_r[DIV_STAGES-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `CHBR_ASSERT_NXT(a_accept_enters, in_valid && in_ready, hv_r[0], "accepted request not in stage 1")
  `CHBR_ASSERT_NXT(a_stall_keeps, last_v && !slot_free, last_v, "stalled request dropped")
  `CHBR_ASSERT_IMP(a_out_from_pipe, $rose(out_valid_r), $past(last_v), "result without source")
  `CHBR_ASSERT_IMP(a_rem_bound, last_v && (dbnd_r[DIV_STAGES-1] != '0), drem_r[DIV_STAGES-1] < dbnd_r[DIV_STAGES-1], "remainder not below bound")

endmodule
